// ===== rtl/dct_pkg.sv =====
// Shared constants and types for the capture table.
package dct_pkg;

   localparam int ENTRIES_DEFAULT     = 16;
   localparam int FRAME_BYTES_DEFAULT = 8;

   // Operation codes.
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // One stored table entry: key and statistics side by side.
   typedef struct packed {
      logic [31:0] freq;
      logic [31:0] rate;
      logic [31:0] deviation;
      logic [31:0] bandwidth;
      logic [31:0] sync;
      logic [7:0]  preamble;
      logic [3:0]  length;
      logic [63:0] bytes;
      logic [7:0]  level;
      logic [63:0] first;
      logic [63:0] latest;
      logic [31:0] hits;
   } entry_type;

   // Divider control handed from the sequencer.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

endpackage

// ===== rtl/dct_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module dct_div
   import dct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output logic        div_done,
   output logic [63:0] quotient
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   // One shift and subtract step.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]} - {1'b0, den_ff};
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

   // Done comes only out of a running division.
   assert property (@(posedge clock) disable iff (reset) div_done |-> $past(busy_ff))
      else $error("divider done without a division in flight");
   // A start never lands while a division runs.
   assert property (@(posedge clock) disable iff (reset) div_req.start |-> !busy_ff)
      else $error("divider restarted while busy");
   // Count is zero whenever idle.
   assert property (@(posedge clock) disable iff (reset) !busy_ff |-> cnt_ff == 7'd0)
      else $error("divider count left over");

endmodule

// ===== rtl/dedup_capture_table_fifo_evict.sv =====
// Capture table top level: entry memory and the scan, update and read sequencer.
// Steps: an add reads and compares each held entry in turn, then writes; clear and
// rejected words go straight to done; a read fetches one entry and, when a period is
// computed, runs one serial divide by 1000*(hits-1).
// One word at a time: busy stays high from start until the result strobe; the receiver
// cannot stall. Reset empties the table at once (fill, oldest pointer, evictions to zero).
module dedup_capture_table_fifo_evict
   import dct_pkg::*;
#(
   parameter int ENTRIES     = ENTRIES_DEFAULT,
   parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [31:0]        req_freq_hz,
   input  logic [31:0]        req_bit_rate,
   input  logic [31:0]        req_deviation,
   input  logic [31:0]        req_band_width,
   input  logic [31:0]        req_sync_pattern,
   input  logic [7:0]         req_preamble_len,
   input  logic [3:0]         req_frame_len,
   input  logic [63:0]        req_frame_data,
   input  logic signed [7:0]  req_signal_dbm,
   input  logic [63:0]        req_seen_time_us,
   input  logic [7:0]         req_entry_index,
   output logic               rsp_valid,
   output logic               rsp_status,
   output logic [7:0]         rsp_slot,
   output logic [8:0]         rsp_entry_count,
   output logic [31:0]        rsp_eviction_total,
   output logic [31:0]        rsp_sightings,
   output logic signed [7:0]  rsp_peak_dbm,
   output logic [63:0]        rsp_last_seen_us,
   output logic [31:0]        rsp_period_ms
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FW = $clog2(ENTRIES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_WRITE, S_READ_RD, S_READ_GOT,
      S_DIV, S_DONE
   } state_type;

   state_type   state_ff;
   entry_type   mem [ENTRIES];
   entry_type   rd_data_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic        rd_en, wr_en;
   entry_type   wr_data;

   logic [AW-1:0] oldest_ff;
   logic [FW-1:0] fill_ff;
   logic [31:0]   evict_ff;
   logic [FW-1:0] pos_ff;
   logic          found_ff;
   entry_type     key_ff;
   logic [1:0]    op_ff;

   div_req_type   div_req;
   logic          div_done;
   logic [63:0]   quotient;
   logic [41:0]   per_den;

   logic [63:0]   mask;
   logic [AW:0]   phys_sum;
   logic [FW-1:0] phys_pos;
   logic          match;
   logic          len_ok;
   logic          bad_cmd;

   // Byte mask from frame length.
   always_comb begin
      mask = '0;
      for (int b = 0; b < 8; b++)
         if (b < int'(req_frame_len)) mask[b*8 +: 8] = 8'hFF;
   end
   assign len_ok = (req_frame_len != 4'd0) && (int'(req_frame_len) <= FRAME_BYTES);

   // Rejected words: bad length, read past fill or unknown operation.
   always_comb begin
      case (req_opcode)
         OP_ADD:   bad_cmd = !len_ok;
         OP_READ:  bad_cmd = ({1'b0, req_entry_index} >= 9'(fill_ff));
         OP_CLEAR: bad_cmd = 1'b0;
         default:  bad_cmd = 1'b1;
      endcase
   end

   // Physical address of a position from oldest.
   always_comb begin
      phys_pos = (state_ff == S_IDLE) ? FW'(req_entry_index) : pos_ff;
      phys_sum = (AW+1)'(oldest_ff) + (AW+1)'(phys_pos);
      if (phys_sum >= (AW+1)'(ENTRIES)) phys_sum = phys_sum - (AW+1)'(ENTRIES);
   end
   assign rd_addr = phys_sum[AW-1:0];

   // Key compare against the word just read.
   assign match = rd_data_ff.freq == key_ff.freq && rd_data_ff.rate == key_ff.rate &&
                  rd_data_ff.deviation == key_ff.deviation &&
                  rd_data_ff.bandwidth == key_ff.bandwidth &&
                  rd_data_ff.sync == key_ff.sync && rd_data_ff.preamble == key_ff.preamble &&
                  rd_data_ff.length == key_ff.length && rd_data_ff.bytes == key_ff.bytes;

   assign rd_en = (state_ff == S_SCAN_RD) || (state_ff == S_READ_RD);

   // Entry memory, one write and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // Write-back contents: merge or fresh entry.
   always_comb begin
      wr_en   = (state_ff == S_WRITE);
      wr_addr = rd_addr;
      wr_data = key_ff;
      if (found_ff) begin
         wr_data = rd_data_ff;
         if (rd_data_ff.hits != 32'hFFFF_FFFF) wr_data.hits = rd_data_ff.hits + 32'd1;
         wr_data.latest = key_ff.latest;
         if ($signed(key_ff.level) > $signed(rd_data_ff.level))
            wr_data.level = key_ff.level;
      end
   end

   // The period is the time span divided once by 1000 times the sighting gaps.
   assign per_den = 42'(rd_data_ff.hits - 32'd1) * 42'd1000;
   assign div_req.start = (state_ff == S_READ_GOT) && rd_data_ff.hits >= 32'd2 &&
                          rd_data_ff.latest > rd_data_ff.first;
   assign div_req.dividend = rd_data_ff.latest - rd_data_ff.first;
   assign div_req.divisor  = {22'd0, per_den};

   dct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .quotient (quotient)
   );

   // Sequencer with registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         oldest_ff <= '0;
         fill_ff   <= '0;
         evict_ff  <= '0;
         busy      <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == S_DONE);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  busy   <= 1'b1;
                  op_ff  <= req_opcode;
                  key_ff.freq      <= req_freq_hz;
                  key_ff.rate      <= req_bit_rate;
                  key_ff.deviation <= req_deviation;
                  key_ff.bandwidth <= req_band_width;
                  key_ff.sync      <= req_sync_pattern;
                  key_ff.preamble  <= req_preamble_len;
                  key_ff.length    <= req_frame_len;
                  key_ff.bytes     <= req_frame_data & mask;
                  key_ff.level     <= req_signal_dbm;
                  key_ff.first     <= req_seen_time_us;
                  key_ff.latest    <= req_seen_time_us;
                  key_ff.hits      <= 32'd1;
                  pos_ff   <= (req_opcode == OP_READ) ? FW'(req_entry_index) : '0;
                  found_ff <= 1'b0;
                  rsp_status <= bad_cmd ? STATUS_BAD : STATUS_OK;
                  rsp_slot <= '0;
                  rsp_sightings <= '0;
                  rsp_peak_dbm <= '0;
                  rsp_last_seen_us <= '0;
                  rsp_period_ms <= '0;
                  case (req_opcode)
                     OP_ADD: begin
                        if (!len_ok) begin
                           state_ff <= S_DONE;
                        end else if (fill_ff == '0) begin
                           state_ff <= S_WRITE;
                        end else begin
                           state_ff <= S_SCAN_RD;
                        end
                     end
                     OP_READ: begin
                        if (bad_cmd) begin
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_READ_RD;
                        end
                     end
                     OP_CLEAR: begin
                        oldest_ff <= '0;
                        fill_ff   <= '0;
                        evict_ff  <= '0;
                        state_ff  <= S_DONE;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_SCAN_RD: state_ff <= S_SCAN_CMP;
            S_SCAN_CMP: begin
               if (match) begin
                  found_ff <= 1'b1;
                  state_ff <= S_WRITE;
               end else if (({1'b0, pos_ff} + (FW+1)'(1)) >= {1'b0, fill_ff}) begin
                  // No hit: evict oldest if full, then append.
                  if (fill_ff == FW'(ENTRIES)) begin
                     oldest_ff <= (oldest_ff == AW'(ENTRIES - 1)) ? '0 : oldest_ff + AW'(1);
                     fill_ff   <= FW'(ENTRIES - 1);
                     evict_ff  <= evict_ff + 32'd1;
                     pos_ff    <= FW'(ENTRIES - 1);
                  end else begin
                     pos_ff <= fill_ff;
                  end
                  state_ff <= S_WRITE;
               end else begin
                  pos_ff   <= pos_ff + FW'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            S_WRITE: begin
               rsp_slot <= 8'(pos_ff);
               if (!found_ff) fill_ff <= fill_ff + FW'(1);
               state_ff <= S_DONE;
            end
            S_READ_RD: state_ff <= S_READ_GOT;
            S_READ_GOT: begin
               rsp_sightings    <= rd_data_ff.hits;
               rsp_peak_dbm     <= rd_data_ff.level;
               rsp_last_seen_us <= rd_data_ff.latest;
               state_ff <= div_req.start ? S_DIV : S_DONE;
            end
            S_DIV: begin
               if (div_done) begin
                  rsp_period_ms <= (quotient[63:32] != '0) ? 32'hFFFF_FFFF : quotient[31:0];
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               rsp_entry_count    <= 9'(fill_ff);
               rsp_eviction_total <= evict_ff;
               busy      <= 1'b0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Fill never exceeds the table.
   assert property (@(posedge clock) disable iff (reset) fill_ff <= FW'(ENTRIES))
      else $error("fill beyond table size");
   // A strobe always ends a busy period.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result while still busy");
   // Memory writes only happen on an add.
   assert property (@(posedge clock) disable iff (reset) wr_en |-> op_ff == OP_ADD)
      else $error("table write outside add");
   // Scan position stays inside the held entries.
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == S_SCAN_CMP |-> pos_ff < fill_ff)
      else $error("scan past fill");

endmodule
